// File: sv/bpl_pkg.sv
// Shared constants, request codes and controller/datapath interface types for the list block.
package bpl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = 5;
    localparam int KIND_W   = 4;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;

    localparam logic [KIND_W-1:0] K_INSERT       = 4'd0;
    localparam logic [KIND_W-1:0] K_INSERT_FRONT = 4'd1;
    localparam logic [KIND_W-1:0] K_INSERT_BACK  = 4'd2;
    localparam logic [KIND_W-1:0] K_REMOVE       = 4'd3;
    localparam logic [KIND_W-1:0] K_REMOVE_FRONT = 4'd4;
    localparam logic [KIND_W-1:0] K_REMOVE_BACK  = 4'd5;
    localparam logic [KIND_W-1:0] K_REPLACE      = 4'd6;
    localparam logic [KIND_W-1:0] K_SELECT       = 4'd7;
    localparam logic [KIND_W-1:0] K_SEARCH       = 4'd8;

    // controller -> datapath
    typedef struct packed {
        logic latch;      // capture the incoming transaction
        logic exec;       // one-cycle strobe: list update / read
        logic walk_step;  // one search compare
        logic load_out;   // move result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_search;
        logic walk_done;
        logic out_free;
    } t_sts;

endpackage

// File: sv/bpl_ctrl.sv
// Sequencing state machine for the list block.
module bpl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bpl_pkg::t_sts i_sts,
    output bpl_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_search) begin
                    n_state = S_WALK;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_stall = r_stall;

endmodule

// File: sv/bpl_datapath.sv
// Entry row, count, search walker and result/output registers of the list block.
module bpl_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bpl_pkg::t_cmd                    i_cmd,
    output bpl_pkg::t_sts                    o_sts,
    input  logic [bpl_pkg::KIND_W-1:0]       i_kind,
    input  logic [bpl_pkg::POS_W-1:0]        i_position,
    input  logic signed [bpl_pkg::VAL_W-1:0] i_item_value,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic                             o_ok,
    output logic signed [bpl_pkg::VAL_W-1:0] o_read_value,
    output logic [bpl_pkg::CNT_W-1:0]        o_found_position,
    output logic [bpl_pkg::CNT_W-1:0]        o_entry_count,
    output logic                             o_is_empty,
    output logic                             o_is_full
);

    localparam int CAP = bpl_pkg::CAPACITY;
    localparam logic [bpl_pkg::CNT_W-1:0] CAP_C = bpl_pkg::CNT_W'(CAP);

    logic [bpl_pkg::VAL_W-1:0]  r_entries [CAP];
    logic [bpl_pkg::VAL_W-1:0]  n_entries [CAP];
    logic [bpl_pkg::CNT_W-1:0]  r_count, n_count;
    logic [bpl_pkg::KIND_W-1:0] r_kind;
    logic [bpl_pkg::POS_W-1:0]  r_pos;
    logic [bpl_pkg::VAL_W-1:0]  r_val;
    logic [bpl_pkg::CNT_W-1:0]  r_walk;

    logic                       r_ok;
    logic [bpl_pkg::VAL_W-1:0]  r_rd;
    logic [bpl_pkg::CNT_W-1:0]  r_found;

    logic                       r_out_valid;
    logic                       r_out_ok;
    logic [bpl_pkg::VAL_W-1:0]  r_out_rd;
    logic [bpl_pkg::CNT_W-1:0]  r_out_found;
    logic [bpl_pkg::CNT_W-1:0]  r_out_count;

    // request decode
    logic                       ins_en, rem_en, rep_en, sel_hit, ex_ok;
    logic [bpl_pkg::CNT_W-1:0]  idx;
    logic [bpl_pkg::IDX_W-1:0]  sel_addr, rd_addr;
    logic [bpl_pkg::VAL_W-1:0]  rd_data, ex_rd;
    logic [bpl_pkg::CNT_W-1:0]  cnt_m1;
    logic                       is_search, walk_end, walk_hit, out_free;

    assign cnt_m1    = r_count - bpl_pkg::CNT_W'(1);
    assign is_search = (r_kind == bpl_pkg::K_SEARCH);
    assign sel_hit   = (bpl_pkg::CNT_W'(r_pos) < r_count);

    always_comb begin
        ins_en   = 1'b0;
        rem_en   = 1'b0;
        rep_en   = 1'b0;
        idx      = '0;
        ex_ok    = 1'b0;
        ex_rd    = '0;
        sel_addr = sel_hit ? r_pos[bpl_pkg::IDX_W-1:0] : cnt_m1[bpl_pkg::IDX_W-1:0];
        unique case (r_kind)
            bpl_pkg::K_INSERT:       idx = bpl_pkg::CNT_W'(r_pos);
            bpl_pkg::K_INSERT_FRONT: idx = '0;
            bpl_pkg::K_INSERT_BACK:  idx = r_count;
            bpl_pkg::K_REMOVE:       idx = bpl_pkg::CNT_W'(r_pos);
            bpl_pkg::K_REMOVE_FRONT: idx = '0;
            bpl_pkg::K_REMOVE_BACK:  idx = cnt_m1;
            default:                 idx = bpl_pkg::CNT_W'(r_pos);
        endcase
        case (r_kind) inside
            bpl_pkg::K_INSERT, bpl_pkg::K_INSERT_FRONT, bpl_pkg::K_INSERT_BACK: begin
                ins_en = (r_count < CAP_C) && (idx <= r_count);
                ex_ok  = ins_en;
            end
            bpl_pkg::K_REMOVE, bpl_pkg::K_REMOVE_FRONT, bpl_pkg::K_REMOVE_BACK: begin
                rem_en = (r_count != '0) && (idx < r_count);
                ex_ok  = rem_en;
            end
            bpl_pkg::K_REPLACE: begin
                rep_en = sel_hit;
                ex_ok  = sel_hit;
            end
            bpl_pkg::K_SELECT: begin
                ex_ok = sel_hit;
                ex_rd = (r_count != '0) ? rd_data : '0;
            end
            default: ;
        endcase
    end

    // single shared read port: walker during a search, select address otherwise
    assign rd_addr = is_search ? r_walk[bpl_pkg::IDX_W-1:0] : sel_addr;
    assign rd_data = r_entries[rd_addr];

    assign walk_end = (r_walk == r_count);
    assign walk_hit = !walk_end && (rd_data == r_val);

    // per-entry shift cells
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        localparam int PREV = (g > 0) ? g - 1 : 0;
        localparam int NEXT = (g < CAP - 1) ? g + 1 : g;
        localparam logic [bpl_pkg::CNT_W-1:0] G_C = bpl_pkg::CNT_W'(g);
        always_comb begin
            n_entries[g] = r_entries[g];
            if (ins_en) begin
                if (G_C == idx)     n_entries[g] = r_val;
                else if (G_C > idx) n_entries[g] = r_entries[PREV];
            end else if (rem_en) begin
                if (G_C >= idx && g < CAP - 1) n_entries[g] = r_entries[NEXT];
            end else if (rep_en) begin
                if (G_C == idx) n_entries[g] = r_val;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_cmd.exec) r_entries[g] <= n_entries[g];
        end
    end

    always_comb begin
        n_count = r_count;
        if (ins_en)      n_count = r_count + bpl_pkg::CNT_W'(1);
        else if (rem_en) n_count = cnt_m1;
    end

    // control state: count, walker, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec)      r_count <= n_count;
            if (i_cmd.latch)     r_walk  <= '0;
            else if (i_cmd.walk_step && !walk_end && !walk_hit)
                r_walk <= r_walk + bpl_pkg::CNT_W'(1);
            if (i_cmd.load_out)  r_out_valid <= 1'b1;
            else if (!i_stall)   r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_kind;
            r_pos  <= i_position;
            r_val  <= i_item_value;
        end
        if (i_cmd.exec) begin
            r_ok    <= ex_ok;
            r_rd    <= ex_rd;
            r_found <= '0;
        end else if (i_cmd.walk_step && (walk_end || walk_hit)) begin
            r_ok    <= walk_hit;
            r_rd    <= '0;
            r_found <= walk_hit ? r_walk : r_count;
        end
        if (i_cmd.load_out) begin
            r_out_ok    <= r_ok;
            r_out_rd    <= r_rd;
            r_out_found <= r_found;
            r_out_count <= r_count;
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    assign o_sts.is_search = is_search;
    assign o_sts.walk_done = walk_end || walk_hit;
    assign o_sts.out_free  = out_free;

    assign o_valid          = r_out_valid;
    assign o_ok             = r_out_ok;
    assign o_read_value     = r_out_rd;
    assign o_found_position = r_out_found;
    assign o_entry_count    = r_out_count;
    assign o_is_empty       = (r_out_count == '0);
    assign o_is_full        = (r_out_count == CAP_C);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count beyond capacity");

    a_count_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_count))
        else $error("entry count moved outside an update cycle");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_step |-> (r_walk <= r_count))
        else $error("search walker ran past the end of the list");

    a_load_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && r_out_valid) |-> !i_stall)
        else $error("result loaded over a pending transaction");

endmodule

// File: sv/bounded_positional_list.sv
// Top level of the bounded ordered list: controller plus datapath.
//
// Usage notes
// - Request channel: i_valid / o_stall with i_kind, i_position, i_item_value.
//   A transaction is taken on a rising edge with i_valid high and o_stall low.
// - Result channel: o_valid / i_stall with o_ok, o_read_value,
//   o_found_position, o_entry_count, o_is_empty, o_is_full. One result per
//   request, in request order.
// - One request at a time. Insert, remove and replace update the 16-entry row
//   (every entry shifts in parallel); select only reads it. o_valid rises when
//   S_EMIT loads the output register; the next request is taken back in S_IDLE.
// - Search walks the entries through the single read port, one compare a
//   cycle, up to count+1 steps per request.
// - The result sits in an output register; the block returns to idle and takes
//   the next request while that result is still waiting on i_stall. A second
//   result waits in the controller until the output register frees.
// - Reset (synchronous, active low) empties the list and drops o_valid. The
//   entry row is not cleared: only entries below the count are ever read.
module bounded_positional_list (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [bpl_pkg::KIND_W-1:0]       i_kind,
    input  logic [bpl_pkg::POS_W-1:0]        i_position,
    input  logic signed [bpl_pkg::VAL_W-1:0] i_item_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_ok,
    output logic signed [bpl_pkg::VAL_W-1:0] o_read_value,
    output logic [bpl_pkg::CNT_W-1:0]        o_found_position,
    output logic [bpl_pkg::CNT_W-1:0]        o_entry_count,
    output logic                             o_is_empty,
    output logic                             o_is_full
);

    bpl_pkg::t_cmd cmd;
    bpl_pkg::t_sts sts;

    // sequencer: accept, update or walk, hand the result over
    bpl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // list storage, search compare and the output register
    bpl_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_kind           (i_kind),
        .i_position       (i_position),
        .i_item_value     (i_item_value),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_ok             (o_ok),
        .o_read_value     (o_read_value),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count),
        .o_is_empty       (o_is_empty),
        .o_is_full        (o_is_full)
    );

endmodule

// File: bench/tb_bounded_positional_list.sv
// Self-checking testbench for the bounded positional list block.
`timescale 1ns / 1ps

module tb_bounded_positional_list;

    // No transaction on either channel for this many cycles means the block has hung.
    // The slowest request is a full-list search with a sender gap and a receiver
    // stall either side, well within this limit.
    localparam int WATCHDOG_LIMIT = 1000;
    // Quiet cycles after the last result, to catch any stray extra result.
    localparam int SETTLE_CYCLES  = 40;
    // Keep the log short if the block is badly broken.
    localparam int REPORT_CAP     = 200;

    // Traffic shapes for the random part.
    typedef enum {
        MIX_GROW,
        MIX_SHRINK,
        MIX_LOOKUP,
        MIX_ANY
    } t_traffic_mix;

    // One expected result, field for field as on the result ports.
    typedef struct packed {
        logic                        ok;
        logic [bpl_pkg::VAL_W-1:0]   read_value;
        logic [bpl_pkg::CNT_W-1:0]   found_pos;
        logic [bpl_pkg::CNT_W-1:0]   count;
        logic                        empty;
        logic                        full;
    } t_list_reply;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic [bpl_pkg::KIND_W-1:0]          i_kind;
    logic [bpl_pkg::POS_W-1:0]           i_position;
    logic signed [bpl_pkg::VAL_W-1:0]    i_item_value;
    logic                                o_valid;
    logic                                i_stall;
    logic                                o_ok;
    logic signed [bpl_pkg::VAL_W-1:0]    o_read_value;
    logic [bpl_pkg::CNT_W-1:0]           o_found_position;
    logic [bpl_pkg::CNT_W-1:0]           o_entry_count;
    logic                                o_is_empty;
    logic                                o_is_full;

    // Shadow copy of the list contents, updated as each request is accepted.
    logic [bpl_pkg::VAL_W-1:0]   shadow_vals [bpl_pkg::CAPACITY];
    int                          shadow_count;

    t_list_reply        pending_replies [$];
    int                 mismatch_count;
    int                 results_seen;
    int                 idle_cycles;
    int                 calm_left;
    bit                 quiet_tail;

    bounded_positional_list dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_position       (i_position),
        .i_item_value     (i_item_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_ok             (o_ok),
        .o_read_value     (o_read_value),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count),
        .o_is_empty       (o_is_empty),
        .o_is_full        (o_is_full)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow list operations
    // ------------------------------------------------------------------

    // Insert at idx, shifting later entries up. Refused when full or past the end;
    // idx equal to the count appends.
    function automatic bit shadow_insert(int idx, logic [bpl_pkg::VAL_W-1:0] v);
        if (shadow_count >= bpl_pkg::CAPACITY || idx > shadow_count)
            return 1'b0;
        for (int i = shadow_count; i > idx; i--)
            shadow_vals[i] = shadow_vals[i-1];
        shadow_vals[idx] = v;
        shadow_count++;
        return 1'b1;
    endfunction

    // Remove at idx, shifting later entries down. Refused when idx is not below the count.
    function automatic bit shadow_remove(int idx);
        if (shadow_count == 0 || idx >= shadow_count)
            return 1'b0;
        for (int i = idx; i + 1 < shadow_count; i++)
            shadow_vals[i] = shadow_vals[i+1];
        shadow_count--;
        return 1'b1;
    endfunction

    // Applies one request to the shadow list and returns the result the block owes.
    function automatic t_list_reply predict_reply(logic [bpl_pkg::KIND_W-1:0] k,
                                                  logic [bpl_pkg::POS_W-1:0] p,
                                                  logic [bpl_pkg::VAL_W-1:0] v);
        t_list_reply r;
        r = '0;
        case (k)
            bpl_pkg::K_INSERT:       r.ok = shadow_insert(int'(p), v);
            bpl_pkg::K_INSERT_FRONT: r.ok = shadow_insert(0, v);
            bpl_pkg::K_INSERT_BACK:  r.ok = shadow_insert(shadow_count, v);
            bpl_pkg::K_REMOVE:       r.ok = shadow_remove(int'(p));
            bpl_pkg::K_REMOVE_FRONT: r.ok = shadow_remove(0);
            bpl_pkg::K_REMOVE_BACK:
                r.ok = (shadow_count != 0) ? shadow_remove(shadow_count - 1) : 1'b0;
            bpl_pkg::K_REPLACE: begin
                // an index equal to the count is out of range
                if (p < shadow_count) begin
                    shadow_vals[p[bpl_pkg::IDX_W-1:0]] = v;
                    r.ok = 1'b1;
                end
            end
            bpl_pkg::K_SELECT: begin
                // out of range still hands back the last entry, or zero when empty
                if (p < shadow_count) begin
                    r.read_value = shadow_vals[p[bpl_pkg::IDX_W-1:0]];
                    r.ok = 1'b1;
                end else if (shadow_count != 0) begin
                    r.read_value = shadow_vals[shadow_count-1];
                end
            end
            bpl_pkg::K_SEARCH: begin
                // walk backwards so the lowest matching index is the one left standing
                r.found_pos = bpl_pkg::CNT_W'(shadow_count);
                for (int i = shadow_count - 1; i >= 0; i--) begin
                    if (shadow_vals[i] == v) begin
                        r.found_pos = bpl_pkg::CNT_W'(i);
                        r.ok = 1'b1;
                    end
                end
            end
            default: ;  // unknown kind: refused, list untouched
        endcase
        r.count = bpl_pkg::CNT_W'(shadow_count);
        r.empty = (shadow_count == 0);
        r.full  = (shadow_count == bpl_pkg::CAPACITY);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random request fields
    // ------------------------------------------------------------------

    function automatic logic [bpl_pkg::KIND_W-1:0] pick_kind(t_traffic_mix mix);
        int roll;
        int grow_pct;
        int shrink_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:   begin grow_pct = 60; shrink_pct = 15; end
            MIX_SHRINK: begin grow_pct = 15; shrink_pct = 60; end
            MIX_LOOKUP: begin grow_pct = 20; shrink_pct = 15; end
            default:    begin grow_pct = 35; shrink_pct = 30; end
        endcase
        if (roll < grow_pct)
            return bpl_pkg::KIND_W'($urandom_range(bpl_pkg::K_INSERT, bpl_pkg::K_INSERT_BACK));
        if (roll < grow_pct + shrink_pct)
            return bpl_pkg::KIND_W'($urandom_range(bpl_pkg::K_REMOVE, bpl_pkg::K_REMOVE_BACK));
        if (roll < 97)
            return bpl_pkg::KIND_W'($urandom_range(bpl_pkg::K_REPLACE, bpl_pkg::K_SEARCH));
        // a small share of undefined kinds
        return bpl_pkg::KIND_W'($urandom_range(bpl_pkg::K_SEARCH + 1,
                                               {bpl_pkg::KIND_W{1'b1}}));
    endfunction

    // Mostly within 0..count (the boundary included), sometimes anywhere in the field.
    function automatic logic [bpl_pkg::POS_W-1:0] pick_position();
        if ($urandom_range(0, 9) < 7)
            return bpl_pkg::POS_W'($urandom_range(0, shadow_count));
        return bpl_pkg::POS_W'($urandom_range(0, (1 << bpl_pkg::POS_W) - 1));
    endfunction

    // A small pool of values makes duplicates, so search has to pick the first match.
    function automatic logic [bpl_pkg::VAL_W-1:0] pick_value(bit want_hit);
        if (want_hit && shadow_count != 0)
            return shadow_vals[$urandom_range(0, shadow_count - 1)];
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(bpl_pkg::VAL_W-1){1'b0}}};
            1:       return {1'b0, {(bpl_pkg::VAL_W-1){1'b1}}};
            2:       return '1;
            3, 4:    return bpl_pkg::VAL_W'($urandom_range(0, 7));
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Presents one request and holds it until taken. Valid is left high on return, so
    // a following request goes out back to back; whoever stops sending lowers it.
    task automatic send_request(logic [bpl_pkg::KIND_W-1:0] k, logic [bpl_pkg::POS_W-1:0] p,
                                logic [bpl_pkg::VAL_W-1:0] v);
        if (!quiet_tail) begin
            if (calm_left > 0) begin
                calm_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else if ($urandom_range(0, 29) == 0) begin
                calm_left = $urandom_range(10, 40);
            end
        end
        i_valid      <= 1'b1;
        i_kind       <= k;
        i_position   <= p;
        i_item_value <= v;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pending_replies.push_back(predict_reply(k, p, v));
    endtask

    task automatic send_random(t_traffic_mix mix);
        logic [bpl_pkg::KIND_W-1:0] k;
        k = pick_kind(mix);
        send_request(k, pick_position(),
                     pick_value(k == bpl_pkg::K_SEARCH && $urandom_range(0, 9) < 6));
    endtask

    // Holds off the sender until every outstanding result has come back.
    task automatic wait_all_replies();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Removes, select, search, replace and an undefined kind against an empty list, plus an insert far past the end.
    task automatic test_empty_list();
        send_request(bpl_pkg::K_REMOVE,       '0, '0);
        send_request(bpl_pkg::K_REMOVE_FRONT, '0, '0);
        send_request(bpl_pkg::K_REMOVE_BACK,  '0, '0);
        send_request(bpl_pkg::K_SELECT,       '0, '1);
        send_request(bpl_pkg::K_SEARCH,       '0, '0);
        send_request(bpl_pkg::K_REPLACE,      '0, 32'h0000_0011);
        send_request(bpl_pkg::K_INSERT,       '1, 32'h0000_0022);
        send_request({bpl_pkg::KIND_W{1'b1}}, '1, '1);
    endtask

    // Inserts at each end and in the middle, boundary indices, hits and misses.
    task automatic test_positional_ops();
        send_request(bpl_pkg::K_INSERT,       5'd0, 32'h8000_0000);
        send_request(bpl_pkg::K_INSERT_FRONT, 5'd0, 32'h7FFF_FFFF);
        send_request(bpl_pkg::K_INSERT_BACK,  5'd0, 32'hFFFF_FFFF);
        send_request(bpl_pkg::K_INSERT,       5'd3, 32'h0000_0000);   // index equal to count
        send_request(bpl_pkg::K_INSERT,       5'd1, 32'h1234_5678);
        send_request(bpl_pkg::K_INSERT,       5'd6, 32'h0000_0001);   // past the end
        send_request(bpl_pkg::K_SELECT,       5'd2, '0);
        send_request(bpl_pkg::K_SELECT,       5'd5, '0);              // out of range
        send_request(bpl_pkg::K_SELECT,       5'd31, '0);
        send_request(bpl_pkg::K_SEARCH,       5'd0, 32'hFFFF_FFFF);
        send_request(bpl_pkg::K_SEARCH,       5'd0, 32'h5555_5555);   // miss: count back
        send_request(bpl_pkg::K_REPLACE,      5'd5, 32'h0BAD_0BAD);   // index equal to count
        send_request(bpl_pkg::K_REPLACE,      5'd4, 32'h8000_0000);   // now a duplicate
        send_request(bpl_pkg::K_SEARCH,       5'd0, 32'h8000_0000);   // first of two matches
        send_request(bpl_pkg::K_REMOVE,       5'd5, '0);
        send_request(bpl_pkg::K_REMOVE,       5'd2, '0);
        send_request(bpl_pkg::K_REMOVE_BACK,  5'd0, '0);
    endtask

    // Alternate filling and emptying runs so both the full and the empty limits are hit.
    task automatic test_capacity_limits();
        for (int round = 0; round < 6; round++) begin
            repeat (50) send_random(MIX_GROW);
            repeat (50) send_random(MIX_SHRINK);
        end
    endtask

    // Select, replace and search heavy traffic over a list of moderate size.
    task automatic test_lookup_traffic();
        repeat (300) send_random(MIX_LOOKUP);
    endtask

    // General traffic; now and then the sender waits for the result queue to empty.
    task automatic test_mixed_with_drains();
        int until_pause;
        until_pause = $urandom_range(60, 120);
        repeat (425) begin
            send_random(MIX_ANY);
            until_pause--;
            if (until_pause == 0) begin
                wait_all_replies();
                until_pause = $urandom_range(60, 120);
            end
        end
    endtask

    // Closing stretch at full rate: no sender gaps and no receiver stalls.
    task automatic test_full_rate_tail();
        quiet_tail = 1'b1;
        calm_left  = 0;
        repeat (200) send_random(MIX_ANY);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [bpl_pkg::VAL_W-1:0] got,
                                   logic [bpl_pkg::VAL_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("%0t: result %0d: %s got %h want %h", $time, results_seen, what, got, want);
    endtask

    task automatic compare_field(string what, logic [bpl_pkg::VAL_W-1:0] got,
                                 logic [bpl_pkg::VAL_W-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Receiver stalls come in bursts, with short and long open stretches.
    initial begin
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (quiet_tail) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_stall <= 1'b0;
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(30, 60)) @(posedge i_clk);
                else
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Each result transaction is checked against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_list_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected result, count",
                                bpl_pkg::VAL_W'(o_entry_count), '0);
            end else begin
                want = pending_replies.pop_front();
                compare_field("ok", bpl_pkg::VAL_W'(o_ok), bpl_pkg::VAL_W'(want.ok));
                compare_field("read_value", o_read_value, want.read_value);
                compare_field("found_position", bpl_pkg::VAL_W'(o_found_position),
                              bpl_pkg::VAL_W'(want.found_pos));
                compare_field("entry_count", bpl_pkg::VAL_W'(o_entry_count),
                              bpl_pkg::VAL_W'(want.count));
                compare_field("is_empty", bpl_pkg::VAL_W'(o_is_empty),
                              bpl_pkg::VAL_W'(want.empty));
                compare_field("is_full", bpl_pkg::VAL_W'(o_is_full),
                              bpl_pkg::VAL_W'(want.full));
            end
            results_seen++;
        end
    end

    // Hang detection: counts cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_kind       <= bpl_pkg::K_INSERT;
        i_position   <= '0;
        i_item_value <= '0;
        idle_cycles  <= 0;
        shadow_count   = 0;
        mismatch_count = 0;
        results_seen   = 0;
        calm_left      = 0;
        quiet_tail     = 1'b0;
        foreach (shadow_vals[i])
            shadow_vals[i] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_positional_ops();
        test_capacity_limits();
        test_lookup_traffic();
        test_mixed_with_drains();
        test_full_rate_tail();

        wait_all_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
sv/bpl_pkg.sv
sv/bpl_ctrl.sv
sv/bpl_datapath.sv
sv/bounded_positional_list.sv
bench/tb_bounded_positional_list.sv
